>>> hdl/imudp_pkg.sv
// ============================================================================
// imudp_pkg
// Shared types and codes for the inertial datagram field parser.
// ============================================================================
`default_nettype none

package imudp_pkg;

    // Field kind codes carried on each result beat
    localparam logic [3:0] KIND_GYRO         = 4'd0;
    localparam logic [3:0] KIND_ACCEL        = 4'd1;
    localparam logic [3:0] KIND_INCLINE      = 4'd2;
    localparam logic [3:0] KIND_GYRO_TEMP    = 4'd3;
    localparam logic [3:0] KIND_ACCEL_TEMP   = 4'd4;
    localparam logic [3:0] KIND_INCLINE_TEMP = 4'd5;
    localparam logic [3:0] KIND_AUX          = 4'd6;
    localparam logic [3:0] KIND_COUNTER      = 4'd7;
    localparam logic [3:0] KIND_LATENCY      = 4'd8;
    localparam logic [3:0] KIND_CRC          = 4'd9;

    // Field position once the CRC has been taken
    localparam logic [4:0] DONE_POS = 5'd20;

    // Register indexes (byte address / 4)
    localparam logic [2:0] REG_INCLUDE_GYRO        = 3'd0;
    localparam logic [2:0] REG_INCLUDE_ACCEL       = 3'd1;
    localparam logic [2:0] REG_INCLUDE_INCLINE     = 3'd2;
    localparam logic [2:0] REG_INCLUDE_TEMPERATURE = 3'd3;
    localparam logic [2:0] REG_INCLUDE_AUXILIARY   = 3'd4;

    // Input beat
    typedef struct packed {
        logic [7:0] data_byte;
        logic       frame_start;
    } in_item_t;

    // Result beat
    typedef struct packed {
        logic [3:0]         field_kind;
        logic [1:0]         axis_index;
        logic signed [23:0] sensor_value;
        logic [31:0]        meta_value;
        logic               status_ok;
        logic               last_field;
    } out_item_t;

    // Section include flags
    typedef struct packed {
        logic include_gyro;
        logic include_accel;
        logic include_incline;
        logic include_temperature;
        logic include_auxiliary;
    } cfg_t;

    // Parser state
    typedef struct packed {
        logic [4:0]  field_position;
        logic [2:0]  byte_in_field;
        logic [1:0]  axis_count;
        logic [31:0] assembly;
        logic        status_seen_nonzero;
    } parse_state_t;

endpackage

`default_nettype wire

>>> hdl/imudp_step.sv
// ============================================================================
// imudp_step
// Next-state and result logic for one payload byte of the datagram.
// ============================================================================
`default_nettype none

module imudp_step import imudp_pkg::*; #(
    parameter int AXIS_COUNT     = 3,
    parameter int INERTIAL_BYTES = 3,
    parameter int TEMP_BYTES     = 2,
    parameter int AUX_BYTES      = 3,
    parameter int LATENCY_BYTES  = 2,
    parameter int CRC_BYTES      = 4
) (
    input  wire parse_state_t state_in,
    input  wire cfg_t         cfg,
    input  wire in_item_t     item,
    output parse_state_t      state_out,
    output out_item_t         result,
    output logic              emit
);

    localparam logic [2:0] INER_N = 3'(INERTIAL_BYTES);
    localparam logic [2:0] TEMP_N = 3'(TEMP_BYTES);
    localparam logic [2:0] AUX_N  = 3'(AUX_BYTES);
    localparam logic [2:0] LAT_N  = 3'(LATENCY_BYTES);
    localparam logic [2:0] CRC_N  = 3'(CRC_BYTES);
    localparam logic [2:0] AXIS_N = 3'(AXIS_COUNT);

    parse_state_t st;
    logic [9:0]   present;
    logic [3:0]   sec;
    logic         sec_start;
    logic [31:0]  base;
    logic [31:0]  asm_new;
    logic [2:0]   n_bytes;
    logic         found;

    // Which sections the datagram holds
    assign present = {3'b111,
                      cfg.include_auxiliary,
                      cfg.include_temperature & cfg.include_incline,
                      cfg.include_temperature & cfg.include_accel,
                      cfg.include_temperature & cfg.include_gyro,
                      cfg.include_incline,
                      cfg.include_accel,
                      cfg.include_gyro};

    always_comb begin
        st        = state_in;
        if (item.frame_start) begin
            st = '0;
        end
        state_out = st;
        result    = '0;
        emit      = 1'b0;
        sec       = st.field_position[4:1];
        sec_start = 1'b0;
        base      = st.assembly;
        asm_new   = '0;
        n_bytes   = 3'd1;
        found     = 1'b0;

        if (st.field_position < DONE_POS) begin
            if (st.field_position[0]) begin
                // Status byte: fold into the flag, move on to the next section
                if (item.data_byte != 8'd0) begin
                    state_out.status_seen_nonzero = 1'b1;
                end
                state_out.field_position = {sec + 4'd1, 1'b0};
            end else begin
                // Section entry: skip sections that are not included
                sec_start = (st.byte_in_field == 3'd0) && (st.axis_count == 2'd0);
                if (sec_start) begin
                    for (int i = 0; i < 10; i++) begin
                        if (!found && (4'(i) >= sec) && present[i]) begin
                            sec   = 4'(i);
                            found = 1'b1;
                        end
                    end
                    base = '0;
                    state_out.field_position = {sec, 1'b0};
                end
                asm_new = {base[23:0], item.data_byte};

                // Bytes in this field
                if (sec <= KIND_INCLINE) begin
                    n_bytes = INER_N;
                end else if (sec <= KIND_INCLINE_TEMP) begin
                    n_bytes = TEMP_N;
                end else if (sec == KIND_AUX) begin
                    n_bytes = AUX_N;
                end else if (sec == KIND_COUNTER) begin
                    n_bytes = 3'd1;
                end else if (sec == KIND_LATENCY) begin
                    n_bytes = LAT_N;
                end else begin
                    n_bytes = CRC_N;
                end

                if ((4'(st.byte_in_field) + 4'd1) < 4'(n_bytes)) begin
                    state_out.byte_in_field = st.byte_in_field + 3'd1;
                    state_out.assembly      = asm_new;
                end else begin
                    // Field complete
                    emit              = 1'b1;
                    result.field_kind = sec;
                    result.axis_index = (sec <= KIND_INCLINE_TEMP) ? st.axis_count : 2'd0;
                    if (sec <= KIND_AUX) begin
                        if (n_bytes == 3'd3) begin
                            result.sensor_value = asm_new[23:0];
                        end else begin
                            result.sensor_value = {{8{asm_new[15]}}, asm_new[15:0]};
                        end
                    end else begin
                        result.meta_value = asm_new;
                    end
                    result.last_field = (sec == KIND_CRC);
                    result.status_ok  = (sec == KIND_CRC) && !st.status_seen_nonzero;

                    state_out.byte_in_field = 3'd0;
                    state_out.assembly      = '0;
                    if (sec <= KIND_INCLINE_TEMP) begin
                        if ((3'(st.axis_count) + 3'd1) >= AXIS_N) begin
                            state_out.axis_count     = 2'd0;
                            state_out.field_position = {sec, 1'b1};
                        end else begin
                            state_out.axis_count = st.axis_count + 2'd1;
                        end
                    end else if (sec == KIND_AUX) begin
                        state_out.field_position = {KIND_AUX, 1'b1};
                    end else if (sec < KIND_CRC) begin
                        state_out.field_position = {sec + 4'd1, 1'b0};
                    end else begin
                        state_out.field_position = DONE_POS;
                    end
                end
            end
        end
    end

endmodule

`default_nettype wire

>>> hdl/imu_datagram_field_parser.sv
// ============================================================================
// imu_datagram_field_parser
// Byte-serial parser for inertial sensor datagram payloads.
// ============================================================================
// Takes one payload byte per clock unless a completed field must wait, and
// returns one result beat per completed field (sensor sample, counter, latency
// or CRC); status bytes and bytes after the CRC give no beat. A byte is
// registered in the input register on acceptance and decoded from there into
// the result register. Throughput is one byte per cycle, set by the single
// decode stage. While a result waits on m_ready, bytes that complete no field
// still move on; the next byte that completes a field holds the input until
// the waiting beat is taken. The include flags must be written over the APB
// port only while the parser is idle; the block itself does not enforce it.
// ============================================================================
`default_nettype none

module imu_datagram_field_parser import imudp_pkg::*; #(
    parameter int AXIS_COUNT     = 3,
    parameter int INERTIAL_BYTES = 3,
    parameter int TEMP_BYTES     = 2,
    parameter int AUX_BYTES      = 3,
    parameter int LATENCY_BYTES  = 2,
    parameter int CRC_BYTES      = 4
) (
    input  wire         aclk,
    input  wire         aresetn,
    // Byte input
    input  wire         s_valid,
    output logic        s_ready,
    input  wire         in_item_t s_payload,
    // Result output
    output logic        m_valid,
    input  wire         m_ready,
    output out_item_t   m_payload,
    // Configuration
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [4:0]  paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    cfg_t         cfg_reg;
    parse_state_t state_reg;
    parse_state_t state_next;
    in_item_t     in_item_reg;
    logic         in_valid_reg;
    out_item_t    out_item_reg;
    out_item_t    result;
    logic         m_valid_reg;
    logic         emit;
    logic         advance;
    logic         cfg_write;

    // Configuration registers
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '{include_gyro: 1'b1, include_accel: 1'b1, include_incline: 1'b1,
                         include_temperature: 1'b1, include_auxiliary: 1'b0};
        end else if (cfg_write) begin
            unique case (paddr[4:2])
                REG_INCLUDE_GYRO:        cfg_reg.include_gyro        <= pwdata[0];
                REG_INCLUDE_ACCEL:       cfg_reg.include_accel       <= pwdata[0];
                REG_INCLUDE_INCLINE:     cfg_reg.include_incline     <= pwdata[0];
                REG_INCLUDE_TEMPERATURE: cfg_reg.include_temperature <= pwdata[0];
                REG_INCLUDE_AUXILIARY:   cfg_reg.include_auxiliary   <= pwdata[0];
                default: ;
            endcase
        end
    end

    // Register read-back
    always_comb begin
        prdata = '0;
        unique case (paddr[4:2])
            REG_INCLUDE_GYRO:        prdata[0] = cfg_reg.include_gyro;
            REG_INCLUDE_ACCEL:       prdata[0] = cfg_reg.include_accel;
            REG_INCLUDE_INCLINE:     prdata[0] = cfg_reg.include_incline;
            REG_INCLUDE_TEMPERATURE: prdata[0] = cfg_reg.include_temperature;
            REG_INCLUDE_AUXILIARY:   prdata[0] = cfg_reg.include_auxiliary;
            default:                 prdata    = '0;
        endcase
    end

    // Decode of the registered byte
    imudp_step #(
        .AXIS_COUNT     (AXIS_COUNT),
        .INERTIAL_BYTES (INERTIAL_BYTES),
        .TEMP_BYTES     (TEMP_BYTES),
        .AUX_BYTES      (AUX_BYTES),
        .LATENCY_BYTES  (LATENCY_BYTES),
        .CRC_BYTES      (CRC_BYTES)
    ) u_step (
        .state_in  (state_reg),
        .cfg       (cfg_reg),
        .item      (in_item_reg),
        .state_out (state_next),
        .result    (result),
        .emit      (emit)
    );

    // Byte leaves the input register unless its result has nowhere to go
    assign advance = in_valid_reg && (!emit || !m_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    // Input register and parser state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            state_reg    <= '0;
        end else begin
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg <= s_payload;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance && emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && emit) begin
            out_item_reg <= result;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_payload = out_item_reg;

endmodule

`default_nettype wire
